// File: rtl/core/rasi_pkg.sv
`default_nettype none
package rasi_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
endpackage
`default_nettype wire

// File: rtl/core/ray_aabb_slab_intersect_top.sv
`default_nettype none
// Ray versus axis-aligned box slab test, signed fixed point.
// Input channel: in_valid/in_stall with ray origin, direction, box centre and
// half extents. Output channel: out_valid/out_stall with hit, distance, point.
// A word is taken every cycle unless stalled. The block is one pipeline that
// advances as a whole whenever the output register is empty or being taken;
// the input stalls only when the output word is held by the receiver.
// The pipeline holds the three axis lanes, each a pair of restoring dividers
// with one quotient bit per stage, followed by the interval merge and hit
// point multiply.
// Throughput: one word per cycle while the output is not stalled.
// Reset clears the valid bits of every stage; data registers are not reset.
// When the receiver stalls, the whole pipeline freezes and nothing is lost.
module ray_aabb_slab_intersect_top #(
    parameter int WORD_BITS = rasi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rasi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [WORD_BITS-1:0] origin_x,
    input  wire logic signed [WORD_BITS-1:0] origin_y,
    input  wire logic signed [WORD_BITS-1:0] origin_z,
    input  wire logic signed [WORD_BITS-1:0] dir_x,
    input  wire logic signed [WORD_BITS-1:0] dir_y,
    input  wire logic signed [WORD_BITS-1:0] dir_z,
    input  wire logic signed [WORD_BITS-1:0] center_x,
    input  wire logic signed [WORD_BITS-1:0] center_y,
    input  wire logic signed [WORD_BITS-1:0] center_z,
    input  wire logic        [WORD_BITS-2:0] half_x,
    input  wire logic        [WORD_BITS-2:0] half_y,
    input  wire logic        [WORD_BITS-2:0] half_z,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             hit,
    output logic signed [WORD_BITS-1:0]      hit_distance,
    output logic signed [WORD_BITS-1:0]      point_x,
    output logic signed [WORD_BITS-1:0]      point_y,
    output logic signed [WORD_BITS-1:0]      point_z
);
    localparam int LANE_LAT = WORD_BITS + FRAC_BITS + 4;
    localparam int LAT = LANE_LAT + 3;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    logic signed [WORD_BITS-1:0] org_in [3], dir_in [3], ctr_in [3];
    logic [WORD_BITS-2:0] half_in [3];
    assign org_in  = '{origin_x, origin_y, origin_z};
    assign dir_in  = '{dir_x, dir_y, dir_z};
    assign ctr_in  = '{center_x, center_y, center_z};
    assign half_in = '{half_x, half_y, half_z};

    // origin and direction ride alongside the lanes
    logic signed [WORD_BITS-1:0] org_dl_reg [LANE_LAT][3];
    logic signed [WORD_BITS-1:0] dir_dl_reg [LANE_LAT][3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            org_dl_reg[0] <= org_in;
            dir_dl_reg[0] <= dir_in;
            for (int s = 1; s < LANE_LAT; s++)
            begin
                org_dl_reg[s] <= org_dl_reg[s-1];
                dir_dl_reg[s] <= dir_dl_reg[s-1];
            end
        end
    end

    logic signed [WORD_BITS-1:0] t_lo [3], t_hi [3];
    logic [2:0] par, par_miss;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        rasi_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
            .clk(clk), .en(en),
            .org(org_in[i]), .dir(dir_in[i]), .ctr(ctr_in[i]), .half(half_in[i]),
            .t_lo(t_lo[i]), .t_hi(t_hi[i]), .par(par[i]), .par_miss(par_miss[i])
        );
    end

    logic signed [WORD_BITS-1:0] pt [3];
    rasi_merge #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_merge (
        .clk(clk), .en(en), .t_lo(t_lo), .t_hi(t_hi), .par(par), .par_miss(par_miss),
        .org(org_dl_reg[LANE_LAT-1]), .dir(dir_dl_reg[LANE_LAT-1]),
        .hit(hit), .hit_distance(hit_distance), .point(pt)
    );
    assign point_x = pt[0];
    assign point_y = pt[1];
    assign point_z = pt[2];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_distance))
        else $error("output word changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == '0 && point_x == '0)
        else $error("miss word not zero");
endmodule
`default_nettype wire

// File: rtl/core/rasi_lane.sv
`default_nettype none
// One axis of the slab test: pipelined restoring dividers for both slab ends.
module rasi_lane #(
    parameter int WORD_BITS = rasi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rasi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [WORD_BITS-1:0] org,
    input  wire logic signed [WORD_BITS-1:0] dir,
    input  wire logic signed [WORD_BITS-1:0] ctr,
    input  wire logic        [WORD_BITS-2:0] half,
    output logic signed [WORD_BITS-1:0]      t_lo,
    output logic signed [WORD_BITS-1:0]      t_hi,
    output logic                             par,
    output logic                             par_miss
);
    localparam int NB = WORD_BITS + 2;          // numerator magnitude bits
    localparam int QB = NB + FRAC_BITS;         // quotient bits produced
    localparam int RB = NB + 1;
    localparam logic [QB-1:0] MAXMAG = {{(QB-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [QB-1:0] n0;   // dividend shifting out (numerator << FRAC)
        logic [RB-1:0] r0;
        logic [QB-1:0] n1;
        logic [RB-1:0] r1;
        logic [WORD_BITS-1:0] dm;
        logic neg0;
        logic neg1;
        logic par;
        logic pmiss;
    } st_t;

    st_t pipe_reg [QB+1];
    st_t st0;
    logic signed [WORD_BITS+1:0] p, a0, a1;
    logic signed [WORD_BITS+1:0] hs;

    always_comb
    begin
        hs = $signed({3'b000, half});
        p  = $signed({{2{ctr[WORD_BITS-1]}}, ctr}) - $signed({{2{org[WORD_BITS-1]}}, org});
        a0 = p + hs;
        a1 = p - hs;
        st0 = '0;
        st0.dm = dir[WORD_BITS-1] ? WORD_BITS'(-dir) : WORD_BITS'(dir);
        st0.n0 = {NB'(a0[WORD_BITS+1] ? -a0 : a0), {FRAC_BITS{1'b0}}};
        st0.n1 = {NB'(a1[WORD_BITS+1] ? -a1 : a1), {FRAC_BITS{1'b0}}};
        st0.neg0 = a0[WORD_BITS+1] != dir[WORD_BITS-1];
        st0.neg1 = a1[WORD_BITS+1] != dir[WORD_BITS-1];
        st0.par = dir == '0;
        st0.pmiss = (p < -hs) || (p > hs);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pipe_reg[0] <= st0;
    end

    // one quotient bit per stage; n shifts up and collects quotient bits at the bottom
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        logic [RB-1:0] r0s, r1s;
        st_t nx;
        always_comb
        begin
            nx = pipe_reg[s];
            r0s = {pipe_reg[s].r0[RB-2:0], pipe_reg[s].n0[QB-1]};
            r1s = {pipe_reg[s].r1[RB-2:0], pipe_reg[s].n1[QB-1]};
            nx.n0 = {pipe_reg[s].n0[QB-2:0], 1'b0};
            nx.n1 = {pipe_reg[s].n1[QB-2:0], 1'b0};
            if (r0s >= RB'(pipe_reg[s].dm))
            begin
                nx.r0 = r0s - RB'(pipe_reg[s].dm);
                nx.n0[0] = 1'b1;
            end
            else
                nx.r0 = r0s;
            if (r1s >= RB'(pipe_reg[s].dm))
            begin
                nx.r1 = r1s - RB'(pipe_reg[s].dm);
                nx.n1[0] = 1'b1;
            end
            else
                nx.r1 = r1s;
        end
        always_ff @(posedge clk)
        begin
            if (en)
                pipe_reg[s+1] <= nx;
        end
    end

    function automatic logic signed [WORD_BITS-1:0] sat_q(input logic [QB-1:0] q,
                                                          input logic neg);
        logic signed [WORD_BITS-1:0] r;
        if (neg)
            r = (q >= MAXMAG) ? {1'b1, {(WORD_BITS-1){1'b0}}} : WORD_BITS'(-q);
        else
            r = (q >= MAXMAG) ? {1'b0, {(WORD_BITS-1){1'b1}}} : WORD_BITS'(q);
        return r;
    endfunction

    logic signed [WORD_BITS-1:0] q0, q1;
    always_comb
    begin
        q0 = sat_q(pipe_reg[QB].n0, pipe_reg[QB].neg0);
        q1 = sat_q(pipe_reg[QB].n1, pipe_reg[QB].neg1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_lo     <= (q0 > q1) ? q1 : q0;
            t_hi     <= (q0 > q1) ? q0 : q1;
            par      <= pipe_reg[QB].par;
            par_miss <= pipe_reg[QB].pmiss;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/rasi_merge.sv
`default_nettype none
// Interval merge, distance pick and hit point multiply.
module rasi_merge #(
    parameter int WORD_BITS = rasi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rasi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [WORD_BITS-1:0] t_lo [3],
    input  wire logic signed [WORD_BITS-1:0] t_hi [3],
    input  wire logic        [2:0]           par,
    input  wire logic        [2:0]           par_miss,
    input  wire logic signed [WORD_BITS-1:0] org [3],
    input  wire logic signed [WORD_BITS-1:0] dir [3],
    output logic                             hit,
    output logic signed [WORD_BITS-1:0]      hit_distance,
    output logic signed [WORD_BITS-1:0]      point [3]
);
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam int PB = 2 * WORD_BITS;

    logic signed [WORD_BITS-1:0] tmin, tmax, t_hit;
    logic miss;
    always_comb
    begin
        tmin = WMIN;
        tmax = WMAX;
        miss = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (!par[i])
            begin
                if (t_lo[i] > tmin) tmin = t_lo[i];
                if (t_hi[i] < tmax) tmax = t_hi[i];
                if (tmin > tmax || tmax < 0) miss = 1'b1;
            end
            else if (par_miss[i])
                miss = 1'b1;
        end
        t_hit = (tmin > 0) ? tmin : tmax;
    end

    logic hit1_reg, hit2_reg;
    logic signed [WORD_BITS-1:0] d1_reg, d2_reg;
    logic signed [WORD_BITS-1:0] o1_reg [3], o2_reg [3], dir1_reg [3];
    logic [PB-1:0] prod_reg [3];
    logic [2:0] neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg <= !miss;
            d1_reg   <= t_hit;
            o1_reg   <= org;
            dir1_reg <= dir;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_mul
        logic [WORD_BITS-1:0] am, bm;
        logic [PB-FRAC_BITS-1:0] sh;
        logic [WORD_BITS:0] mag;
        logic signed [WORD_BITS+1:0] sum;
        always_comb
        begin
            am = d1_reg[WORD_BITS-1] ? WORD_BITS'(-d1_reg) : WORD_BITS'(d1_reg);
            bm = dir1_reg[i][WORD_BITS-1] ? WORD_BITS'(-dir1_reg[i]) : WORD_BITS'(dir1_reg[i]);
            sh = prod_reg[i][PB-1:FRAC_BITS];
            mag = (sh > (PB-FRAC_BITS)'({1'b1, {WORD_BITS{1'b0}}}))
                ? {1'b1, {WORD_BITS{1'b0}}} : (WORD_BITS+1)'(sh);
            sum = $signed({{2{o2_reg[i][WORD_BITS-1]}}, o2_reg[i]})
                + (neg_reg[i] ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[i] <= PB'(am) * PB'(bm);
                neg_reg[i]  <= d1_reg[WORD_BITS-1] != dir1_reg[i][WORD_BITS-1];
                o2_reg[i]   <= o1_reg[i];
                if (!hit2_reg)
                    point[i] <= '0;
                else if (sum > WMAX)
                    point[i] <= WMAX;
                else if (sum < WMIN)
                    point[i] <= WMIN;
                else
                    point[i] <= WORD_BITS'(sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit2_reg     <= hit1_reg;
            d2_reg       <= hit1_reg ? d1_reg : '0;
            hit          <= hit2_reg;
            hit_distance <= d2_reg;
        end
    end
endmodule
`default_nettype wire

// File: test/ray_box_checker.sv
`timescale 1ns / 100ps
module ray_box_checker #(
    parameter int WB = rasi_pkg::WORD_BITS_DEF,
    parameter int FB = rasi_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [WB-1:0] origin_x,
    input  logic signed [WB-1:0] origin_y,
    input  logic signed [WB-1:0] origin_z,
    input  logic signed [WB-1:0] dir_x,
    input  logic signed [WB-1:0] dir_y,
    input  logic signed [WB-1:0] dir_z,
    input  logic signed [WB-1:0] center_x,
    input  logic signed [WB-1:0] center_y,
    input  logic signed [WB-1:0] center_z,
    input  logic        [WB-2:0] half_x,
    input  logic        [WB-2:0] half_y,
    input  logic        [WB-2:0] half_z,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 hit,
    input  logic signed [WB-1:0] hit_distance,
    input  logic signed [WB-1:0] point_x,
    input  logic signed [WB-1:0] point_y,
    input  logic signed [WB-1:0] point_z,
    output int                   errors,
    output int                   pending
);
    localparam longint WMAX = (longint'(1) << (WB - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;

    typedef struct packed {
        logic         hit;
        logic [WB-1:0] t_hit;
        logic [WB-1:0] px;
        logic [WB-1:0] py;
        logic [WB-1:0] pz;
    } hit_word_t;

    hit_word_t hits_due[$];

    function automatic longint sat_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // truncating quotient in Q format; numerator fits well inside 64 bits
    function automatic longint slab_quot(longint n, longint d);
        logic           neg;
        logic [127:0]   nm, dm, q;
        longint         r;
        neg = (n < 0) != (d < 0);
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = (nm << FB) / dm;
        if (neg)
            r = (q > (128'(1) << (WB - 1))) ? WMIN : -longint'(q);
        else
            r = (q > 128'(WMAX)) ? WMAX : longint'(q);
        return r;
    endfunction

    function automatic longint walk(longint o, longint t, longint d);
        logic           neg;
        logic [127:0]   a, b, m;
        longint         p;
        neg = (t < 0) != (d < 0);
        a = (t < 0) ? -t : t;
        b = (d < 0) ? -d : d;
        m = (a * b) >> FB;
        if (m > (128'(1) << WB)) m = 128'(1) << WB;
        p = neg ? -longint'(m) : longint'(m);
        return sat_word(o + p);
    endfunction

    function automatic hit_word_t slab_test(longint o[3], longint d[3], longint c[3],
                                           longint h[3]);
        hit_word_t w;
        longint    tmin, tmax, p, t0, t1, tt, t_hit;
        logic      miss;
        tmin = WMIN;
        tmax = WMAX;
        miss = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = c[i] - o[i];
            if (d[i] != 0)
            begin
                t0 = slab_quot(p + h[i], d[i]);
                t1 = slab_quot(p - h[i], d[i]);
                if (t0 > t1)
                begin
                    tt = t0; t0 = t1; t1 = tt;
                end
                if (t0 > tmin) tmin = t0;
                if (t1 < tmax) tmax = t1;
                if (tmin > tmax || tmax < 0) miss = 1;
            end
            else if (p < -h[i] || p > h[i])
                miss = 1;
        end
        w = '0;
        if (!miss)
        begin
            t_hit = (tmin > 0) ? tmin : tmax;
            w.hit = 1;
            w.t_hit = t_hit[WB-1:0];
            tt = walk(o[0], t_hit, d[0]); w.px = tt[WB-1:0];
            tt = walk(o[1], t_hit, d[1]); w.py = tt[WB-1:0];
            tt = walk(o[2], t_hit, d[2]); w.pz = tt[WB-1:0];
        end
        return w;
    endfunction

    task automatic report(string what, logic [WB-1:0] got, logic [WB-1:0] want);
        errors++;
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    assign pending = hits_due.size();

    initial errors = 0;

    always @(posedge clk)
    begin
        longint    o[3], d[3], c[3], h[3];
        hit_word_t w;
        if (rst_n && in_valid && !in_stall)
        begin
            o = '{origin_x, origin_y, origin_z};
            d = '{dir_x, dir_y, dir_z};
            c = '{center_x, center_y, center_z};
            h = '{half_x, half_y, half_z};
            hits_due.push_back(slab_test(o, d, c, h));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (hits_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word", $realtime);
            end
            else
            begin
                w = hits_due.pop_front();
                if (hit !== w.hit) report("hit", hit, w.hit);
                if (hit_distance !== w.t_hit) report("hit_distance", hit_distance, w.t_hit);
                if (point_x !== w.px) report("point_x", point_x, w.px);
                if (point_y !== w.py) report("point_y", point_y, w.py);
                if (point_z !== w.pz) report("point_z", point_z, w.pz);
            end
        end
    end
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
module testbench;
    localparam int WB = rasi_pkg::WORD_BITS_DEF;
    localparam int LATENCY = rasi_pkg::WORD_BITS_DEF + rasi_pkg::FRAC_BITS_DEF + 7;
    localparam int IDLE_LIMIT = 20000;

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, hit;
    logic signed [WB-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic signed [WB-1:0] center_x, center_y, center_z;
    logic        [WB-2:0] half_x, half_y, half_z;
    logic signed [WB-1:0] hit_distance, point_x, point_y, point_z;
    int errors, pending, idle_cycles;
    int send_idle, recv_stall;

    ray_aabb_slab_intersect_top i_dut (.*);
    ray_box_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stall at the chosen rate
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [WB-1:0] rand_word(int kind);
        case (kind)
            0: return {1'b0, {(WB - 1){1'b1}}};
            1: return {1'b1, {(WB - 1){1'b0}}};
            2: return '0;
            3: return WB'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            4: return WB'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            default: return $urandom;
        endcase
    endfunction

    // one word; mode 1 likely hit, mode 2 extremes, any other mode random
    task automatic send(int mode);
        logic [WB-1:0] o[3], d[3], c[3], h[3];
        for (int i = 0; i < 3; i++)
        begin
            if (mode == 1)
            begin
                o[i] = rand_word(3);
                d[i] = ($urandom_range(9) == 0) ? '0 : rand_word(4);
                c[i] = rand_word(3);
                h[i] = $urandom_range(0, 12 << 16);
            end
            else if (mode == 2)
            begin
                o[i] = rand_word($urandom_range(0, 2));
                d[i] = rand_word($urandom_range(0, 2));
                c[i] = rand_word($urandom_range(0, 2));
                h[i] = rand_word($urandom_range(0, 2));
            end
            else
            begin
                o[i] = rand_word($urandom_range(0, 5));
                d[i] = rand_word($urandom_range(0, 5));
                c[i] = rand_word($urandom_range(0, 5));
                h[i] = rand_word($urandom_range(0, 5));
            end
        end
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        {origin_x, origin_y, origin_z} <= {o[0], o[1], o[2]};
        {dir_x, dir_y, dir_z} <= {d[0], d[1], d[2]};
        {center_x, center_y, center_z} <= {c[0], c[1], c[2]};
        {half_x, half_y, half_z} <= {h[0][WB-2:0], h[1][WB-2:0], h[2][WB-2:0]};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_ray(logic [WB-1:0] ox, logic [WB-1:0] dx, logic [WB-1:0] cx,
                            logic [WB-2:0] hx);
        in_valid <= 1;
        {origin_x, origin_y, origin_z} <= {ox, 32'h0, 32'h0};
        {dir_x, dir_y, dir_z} <= {dx, 32'h0, 32'h0};
        {center_x, center_y, center_z} <= {cx, 32'h0, 32'h0};
        {half_x, half_y, half_z} <= {hx, 31'h10000, 31'h10000};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
        {center_x, center_y, center_z, half_x, half_y, half_z} = '0;
        send_idle = 0;
        recv_stall = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: hit ahead, origin inside, box behind, parallel in/out, tiny dir
        send_ray(32'h0, 32'h10000, 32'h50000, 31'h10000);
        send_ray(32'h50000, 32'h10000, 32'h50000, 31'h20000);
        send_ray(32'h0, 32'h10000, -32'h50000, 31'h10000);
        send_ray(32'h0, 32'h0, 32'h0, 31'h10000);
        send_ray(32'h0, 32'h0, 32'h50000, 31'h10000);
        send_ray(32'h0, 32'h1, 32'h7fff0000, 31'h10000);
        send_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        send_ray(32'h7fffffff, 32'h80000000, 32'h80000000, 31'h0);
        send_ray(32'h0, -32'h10000, -32'h50000, 31'h10000);
        send_ray(32'h0, 32'h10000, 32'h10000, 31'h10000);
        for (int k = 0; k < 12; k++) send(2);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 28) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 64 : 28) : 0;
            for (int k = 0; k < 460; k++) send(($urandom_range(3) == 0) ? 0 : 1);
            // hold off until the pipe drains
            in_valid <= 0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
        end
        in_valid <= 0;
        recv_stall = 0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: files.f
rtl/core/rasi_pkg.sv
rtl/core/rasi_lane.sv
rtl/core/rasi_merge.sv
rtl/core/ray_aabb_slab_intersect_top.sv
test/ray_box_checker.sv
test/testbench.sv
